// File: design/pfci_pkg.sv
// Shared types and constants for the paged flash command interface.
// Used by the control block, the word store and the top level; no dependencies.
package pfci_pkg;

	// Bus and array geometry.
	localparam int ADDR_W      = 17;
	localparam int DATA_W      = 16;
	localparam int STORE_WORDS = 131072;
	localparam int STORE_AW    = $clog2(STORE_WORDS);
	localparam int COUNT_W     = 8;
	localparam int TICK_W      = 16;
	localparam int CFG_IDX_W   = 2;

	// Unlock sequence and command words.
	localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = ADDR_W'(17'h05555);
	localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = ADDR_W'(17'h02AAA);
	localparam logic [DATA_W-1:0] UNLOCK_DATA1 = 16'hAAAA;
	localparam logic [DATA_W-1:0] UNLOCK_DATA2 = 16'h5555;
	localparam logic [DATA_W-1:0] OP_ID_ENTER  = 16'h9090;
	localparam logic [DATA_W-1:0] OP_ID_EXIT   = 16'hF0F0;
	localparam logic [DATA_W-1:0] OP_PAGE      = 16'hA0A0;
	localparam logic [ADDR_W-1:0] ID_ADDR_VENDOR = '0;
	localparam logic [ADDR_W-1:0] ID_ADDR_DEVICE = ADDR_W'(1);
	localparam logic [TICK_W-1:0] TICK_MAX     = '1;

	// Configuration reset values.
	localparam logic [DATA_W-1:0]  VENDOR_RESET  = 16'hBFBF;
	localparam logic [DATA_W-1:0]  DEVICE_RESET  = 16'h0707;
	localparam logic [COUNT_W-1:0] PAGE_WORDS_RESET   = 8'd128;
	localparam logic [TICK_W-1:0]  PAGE_TIMEOUT_RESET = 16'd100;

	typedef logic [STORE_AW-1:0] store_idx_t;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_READ = 2'd0,
		MODE_ID   = 2'd1,
		MODE_PAGE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		UNLOCK_IDLE = 2'd0,
		UNLOCK_GOT1 = 2'd1,
		UNLOCK_GOT2 = 2'd2
	} unlock_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VENDOR       = 2'd0,
		REG_DEVICE       = 2'd1,
		REG_PAGE_WORDS   = 2'd2,
		REG_PAGE_TIMEOUT = 2'd3
	} cfg_reg_t;

	// Configuration register set.
	typedef struct packed {
		logic [DATA_W-1:0]  vendor_code;
		logic [DATA_W-1:0]  device_code;
		logic [COUNT_W-1:0] page_words;
		logic [TICK_W-1:0]  page_timeout;
	} cfg_t;

	// One access to the word store.
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		store_idx_t        idx;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	// Array index: the word address modulo the store depth.
	function automatic store_idx_t store_index(input logic [ADDR_W-1:0] addr);
		return store_idx_t'(addr);
	endfunction

endpackage

// File: design/pfci_store.sv
// Word array of the flash model: one access per cycle, registered read data.
// Depends on pfci_pkg for the depth and the request struct.
module pfci_store import pfci_pkg::*; (
	input  logic              clk,
	input  mem_req_t          req,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [STORE_WORDS];
	logic [DATA_W-1:0] rdata_q;

	// Write or read at the requested word; contents are undefined until written.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.idx] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.idx];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/pfci_ctrl.sv
// Command decoder, unlock sequencer and page write control of the flash model.
// Depends on pfci_pkg; drives the word store through a request struct.
module pfci_ctrl import pfci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cmd_t              cmd,
	input  logic [ADDR_W-1:0] word_addr,
	input  logic [DATA_W-1:0] write_word,
	input  cfg_t              cfg,
	input  logic [DATA_W-1:0] mem_rdata,
	output mem_req_t          mem_req,
	output logic              done,
	output logic [DATA_W-1:0] read_word,
	output mode_t             mode_now,
	output logic              stored,
	output logic              page_closed
);

	mode_t              mode_q, mode_d;
	unlock_t            unlock_q, unlock_d;
	logic [COUNT_W-1:0] words_left_q, words_left_d;
	logic [TICK_W-1:0]  idle_q, idle_d;
	logic [TICK_W-1:0]  idle_inc;

	logic               stored_d, closed_d, use_mem_d;
	logic [DATA_W-1:0]  word_d;

	logic               valid_s1;
	logic               stored_s1, closed_s1, use_mem_s1;
	logic [DATA_W-1:0]  word_s1;

	// Control state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_READ;
			unlock_q     <= UNLOCK_IDLE;
			words_left_q <= '0;
			idle_q       <= '0;
		end else if (accept) begin
			mode_q       <= mode_d;
			unlock_q     <= unlock_d;
			words_left_q <= words_left_d;
			idle_q       <= idle_d;
		end
	end

	assign idle_inc = (idle_q != TICK_MAX) ? idle_q + TICK_W'(1) : idle_q;

	// Next state and result fields for the request at the input.
	always_comb begin
		mode_d       = mode_q;
		unlock_d     = unlock_q;
		words_left_d = words_left_q;
		idle_d       = idle_q;
		stored_d     = 1'b0;
		closed_d     = 1'b0;
		use_mem_d    = 1'b0;
		word_d       = '0;

		mem_req.rd_en = 1'b0;
		mem_req.wr_en = 1'b0;
		mem_req.idx   = store_index(word_addr);
		mem_req.wdata = write_word;

		unique case (cmd)
			CMD_READ: begin
				if (mode_q == MODE_ID && word_addr == ID_ADDR_VENDOR) begin
					word_d = cfg.vendor_code;
				end else if (mode_q == MODE_ID && word_addr == ID_ADDR_DEVICE) begin
					word_d = cfg.device_code;
				end else begin
					use_mem_d     = 1'b1;
					mem_req.rd_en = accept;
				end
			end
			CMD_WRITE: begin
				if (mode_q == MODE_PAGE) begin
					// Page data word: store it and count it off.
					mem_req.wr_en = accept;
					stored_d      = 1'b1;
					idle_d        = '0;
					unlock_d      = UNLOCK_IDLE;
					if (words_left_q <= COUNT_W'(1)) begin
						mode_d       = MODE_READ;
						words_left_d = '0;
						closed_d     = 1'b1;
					end else begin
						words_left_d = words_left_q - COUNT_W'(1);
					end
				end else begin
					unique case (unlock_q)
						UNLOCK_IDLE: begin
							unlock_d = (word_addr == UNLOCK_ADDR1 && write_word == UNLOCK_DATA1)
								? UNLOCK_GOT1 : UNLOCK_IDLE;
						end
						UNLOCK_GOT1: begin
							unlock_d = (word_addr == UNLOCK_ADDR2 && write_word == UNLOCK_DATA2)
								? UNLOCK_GOT2 : UNLOCK_IDLE;
						end
						default: begin
							// Third write of the sequence carries the command.
							unlock_d = UNLOCK_IDLE;
							if (word_addr == UNLOCK_ADDR1) begin
								if (write_word == OP_ID_ENTER) begin
									mode_d = MODE_ID;
								end else if (write_word == OP_ID_EXIT) begin
									mode_d = MODE_READ;
								end else if (write_word == OP_PAGE) begin
									if (cfg.page_words == '0) begin
										closed_d = 1'b1;
									end else begin
										mode_d       = MODE_PAGE;
										words_left_d = cfg.page_words;
										idle_d       = '0;
									end
								end
							end
						end
					endcase
				end
			end
			CMD_TICK: begin
				if (mode_q == MODE_PAGE) begin
					idle_d = idle_inc;
					if (idle_inc >= cfg.page_timeout) begin
						mode_d       = MODE_READ;
						words_left_d = '0;
						idle_d       = '0;
						unlock_d     = UNLOCK_IDLE;
						closed_d     = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Result payload, held alongside the store's registered read data.
	always_ff @(posedge clk) begin
		if (accept) begin
			stored_s1  <= stored_d;
			closed_s1  <= closed_d;
			use_mem_s1 <= use_mem_d;
			word_s1    <= word_d;
		end
	end

	assign done        = valid_s1;
	assign read_word   = use_mem_s1 ? mem_rdata : word_s1;
	assign mode_now    = mode_q;
	assign stored      = stored_s1;
	assign page_closed = closed_s1;

endmodule

// File: design/paged_flash_command_interface_top.sv
// Paged flash command interface: done pulses in the cycle after the request
// is taken. Throughput is one request per cycle, set by the single-port
// word store that serves either the read or the page write of each request.
// busy is always low and results cannot be stalled. Reset clears the mode, unlock
// and page counters and restores the configuration; array words stay undefined
// until written, with no clearing pass.
module paged_flash_command_interface_top import pfci_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [ADDR_W-1:0]    word_addr,
	input  logic [DATA_W-1:0]    write_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_wdata,
	output logic                 done,
	output logic [DATA_W-1:0]    read_word,
	output logic [1:0]           mode_now,
	output logic                 stored,
	output logic                 page_closed
);

	cfg_t              cfg_q;
	mem_req_t          mem_req;
	logic [DATA_W-1:0] mem_rdata;
	logic              accept;
	mode_t             mode_w;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vendor_code  <= VENDOR_RESET;
			cfg_q.device_code  <= DEVICE_RESET;
			cfg_q.page_words   <= PAGE_WORDS_RESET;
			cfg_q.page_timeout <= PAGE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_VENDOR:       cfg_q.vendor_code  <= cfg_wdata;
				REG_DEVICE:       cfg_q.device_code  <= cfg_wdata;
				REG_PAGE_WORDS:   cfg_q.page_words   <= cfg_wdata[COUNT_W-1:0];
				REG_PAGE_TIMEOUT: cfg_q.page_timeout <= cfg_wdata[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pfci_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd_t'(cmd)),
		.word_addr   (word_addr),
		.write_word  (write_word),
		.cfg         (cfg_q),
		.mem_rdata   (mem_rdata),
		.mem_req     (mem_req),
		.done        (done),
		.read_word   (read_word),
		.mode_now    (mode_w),
		.stored      (stored),
		.page_closed (page_closed)
	);

	pfci_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign mode_now = mode_w;

endmodule
